// ===== src/mlfq_pkg.sv =====
// Shared types and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

   localparam int TIME_W = 16;
   localparam int WORK_W = 8;
   localparam int LEVEL_W = 2;
   localparam int SLOT_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PASS = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_TWO = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM_ONE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM_TWO = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM_THREE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_LIMIT = 2'd3;

   localparam logic [WORK_W-1:0] QUANTUM_ONE_RESET = 8'd2;
   localparam logic [WORK_W-1:0] QUANTUM_TWO_RESET = 8'd4;
   localparam logic [WORK_W-1:0] QUANTUM_THREE_RESET = 8'd6;
   localparam logic [TIME_W-1:0] WAIT_LIMIT_RESET = 16'd6;

   typedef struct packed {
      logic [WORK_W-1:0]  work;
      logic [TIME_W-1:0]  arrival;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  waited;
   } rec_type;

   typedef struct packed {
      logic start_load;
      logic start_pass;
      logic scan_next;
      logic take_slice;
      logic age_issue;
      logic self_wr;
      logic out_slice;
      logic out_final;
   } cmd_type;

   typedef struct packed {
      logic busy_cur;
      logic eligible;
      logic scan_last;
      logic age_last;
      logic out_free;
   } status_type;

endpackage

// ===== src/mlfq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mlfq_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 32,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mlfq_ctrl.sv =====
// Sequencing state machine for loads, slot scans, aging sweeps and results.
module mlfq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_stall,
   input  mlfq_pkg::status_type status,
   output mlfq_pkg::cmd_type    cmd
);
   import mlfq_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SCAN_RD,
      SCAN_EV,
      AGE,
      AGE_DRAIN,
      SELF_WR,
      EMIT,
      FINAL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.start_load = 1'b1;
                  state_in = FINAL;
               end else begin
                  cmd.start_pass = 1'b1;
                  state_in = SCAN_RD;
               end
            end
         end
         SCAN_RD: begin
            if (status.busy_cur) begin
               state_in = SCAN_EV;
            end else if (status.scan_last) begin
               state_in = FINAL;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         SCAN_EV: begin
            if (status.eligible) begin
               cmd.take_slice = 1'b1;
               state_in = AGE;
            end else if (status.scan_last) begin
               state_in = FINAL;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = SCAN_RD;
            end
         end
         AGE: begin
            cmd.age_issue = 1'b1;
            if (status.age_last) begin
               state_in = AGE_DRAIN;
            end
         end
         AGE_DRAIN: begin
            state_in = SELF_WR;
         end
         SELF_WR: begin
            cmd.self_wr = 1'b1;
            state_in = EMIT;
         end
         EMIT: begin
            if (status.out_free) begin
               cmd.out_slice = 1'b1;
               if (status.scan_last) begin
                  state_in = FINAL;
               end else begin
                  cmd.scan_next = 1'b1;
                  state_in = SCAN_RD;
               end
            end
         end
         FINAL: begin
            if (status.out_free) begin
               cmd.out_final = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE);

endmodule

// ===== src/mlfq_datapath.sv =====
// Slot store, busy bits, clock, slice arithmetic, aging sweep and output register.
module mlfq_datapath #(
   parameter int TASK_SLOTS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mlfq_pkg::cmd_type              cmd,
   output mlfq_pkg::status_type           status,
   input  logic [mlfq_pkg::SLOT_W-1:0]    req_slot,
   input  logic [mlfq_pkg::TIME_W-1:0]    req_arrival_time,
   input  logic [mlfq_pkg::WORK_W-1:0]    req_service_time,
   input  logic [mlfq_pkg::LEVEL_W-1:0]   req_level,
   input  logic                           csr_write_enable,
   input  logic [mlfq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_slice_valid,
   output logic [mlfq_pkg::SLOT_W-1:0]    rsp_task_slot,
   output logic [mlfq_pkg::TIME_W-1:0]    rsp_start_time,
   output logic [mlfq_pkg::WORK_W-1:0]    rsp_run_length,
   output logic [mlfq_pkg::WORK_W-1:0]    rsp_work_left,
   output logic                           rsp_finished,
   output logic [mlfq_pkg::TIME_W-1:0]    rsp_end_time,
   output logic                           rsp_all_done,
   output logic                           rsp_last
);
   import mlfq_pkg::*;

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int REC_W = $bits(rec_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

   logic [WORK_W-1:0] quantum_one_ff, quantum_two_ff, quantum_three_ff;
   logic [TIME_W-1:0] wait_limit_ff;

   logic [TASK_SLOTS-1:0] busy_ff;
   logic [TIME_W-1:0]     time_ff;
   logic [IDX_W-1:0]      scan_idx_ff, age_idx_ff, age_idx_d_ff;
   logic                  age_v_ff;
   logic [LEVEL_W-1:0]    pass_level_ff;
   logic [WORK_W-1:0]     quantum_ff, run_ff;
   logic [TIME_W-1:0]     start_ff;
   rec_type               self_rec_ff;

   logic                  rsp_valid_ff, rsp_slice_valid_ff, rsp_finished_ff;
   logic                  rsp_all_done_ff, rsp_last_ff;
   logic [SLOT_W-1:0]     rsp_task_slot_ff;
   logic [TIME_W-1:0]     rsp_start_time_ff, rsp_end_time_ff;
   logic [WORK_W-1:0]     rsp_run_length_ff, rsp_work_left_ff;

   logic [LEVEL_W-1:0]    req_level_norm;
   logic [WORK_W-1:0]     quantum_sel;
   logic                  load_we;
   logic [IDX_W-1:0]      load_idx;
   rec_type               rd_rec, load_rec, age_rec, wr_rec;
   logic [REC_W-1:0]      ram_rd_data;
   logic [IDX_W-1:0]      ram_rd_addr, ram_wr_addr;
   logic                  ram_we;
   logic [WORK_W-1:0]     run_calc, work_after;
   logic [TIME_W:0]       time_sum, wait_sum;
   logic [TIME_W-1:0]     time_sat, wait_sat;
   logic [LEVEL_W-1:0]    self_level;
   logic                  age_we, promote, out_free;

   assign req_level_norm = (req_level == LEVEL_NONE) ? LEVEL_ONE : req_level;

   always_comb begin
      unique case (req_level_norm)
         LEVEL_ONE: quantum_sel = quantum_one_ff;
         LEVEL_TWO: quantum_sel = quantum_two_ff;
         default:   quantum_sel = quantum_three_ff;
      endcase
   end

   assign load_we = cmd.start_load && (req_slot < SLOT_W'(TASK_SLOTS));
   assign load_idx = req_slot[IDX_W-1:0];
   assign load_rec = '{work: req_service_time, arrival: req_arrival_time,
                       level: req_level_norm, waited: '0};

   assign rd_rec = rec_type'(ram_rd_data);

   // Slice arithmetic on the record of the scanned slot.
   assign run_calc = (rd_rec.work > quantum_ff) ? quantum_ff : rd_rec.work;
   assign work_after = rd_rec.work - run_calc;
   assign time_sum = {1'b0, time_ff} + {{(TIME_W + 1 - WORK_W){1'b0}}, run_calc};
   assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
   assign self_level = ((work_after != '0) && (pass_level_ff != LEVEL_THREE)) ?
                       pass_level_ff + LEVEL_ONE : pass_level_ff;

   // Aging on the record read in the previous cycle.
   assign age_rec = rd_rec;
   assign wait_sum = {1'b0, age_rec.waited} + {{(TIME_W + 1 - WORK_W){1'b0}}, run_ff};
   assign wait_sat = wait_sum[TIME_W] ? '1 : wait_sum[TIME_W-1:0];
   assign promote = (wait_sat > wait_limit_ff) && (age_rec.level != LEVEL_ONE);
   assign age_we = age_v_ff && (age_rec.arrival <= time_ff);

   always_comb begin
      ram_we = 1'b0;
      ram_wr_addr = load_idx;
      wr_rec = load_rec;
      priority if (load_we) begin
         ram_we = 1'b1;
      end else if (age_we) begin
         ram_we = 1'b1;
         ram_wr_addr = age_idx_d_ff;
         wr_rec = age_rec;
         if (promote) begin
            wr_rec.level = age_rec.level - LEVEL_ONE;
            wr_rec.waited = '0;
         end else begin
            wr_rec.waited = wait_sat;
         end
      end else if (cmd.self_wr) begin
         ram_we = 1'b1;
         ram_wr_addr = scan_idx_ff;
         wr_rec = self_rec_ff;
      end
   end

   assign ram_rd_addr = cmd.age_issue ? age_idx_ff : scan_idx_ff;

   mlfq_ram #(
      .WIDTH (REC_W),
      .DEPTH (TASK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_rec),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_one_ff <= QUANTUM_ONE_RESET;
         quantum_two_ff <= QUANTUM_TWO_RESET;
         quantum_three_ff <= QUANTUM_THREE_RESET;
         wait_limit_ff <= WAIT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_QUANTUM_ONE:   quantum_one_ff <= csr_write_data[WORK_W-1:0];
            CSR_QUANTUM_TWO:   quantum_two_ff <= csr_write_data[WORK_W-1:0];
            CSR_QUANTUM_THREE: quantum_three_ff <= csr_write_data[WORK_W-1:0];
            CSR_WAIT_LIMIT:    wait_limit_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         time_ff <= '0;
         scan_idx_ff <= '0;
         age_idx_ff <= '0;
         age_v_ff <= 1'b0;
      end else begin
         age_v_ff <= cmd.age_issue && busy_ff[age_idx_ff] && (age_idx_ff != scan_idx_ff);
         if (load_we) begin
            busy_ff[load_idx] <= (req_service_time != '0);
         end
         if (cmd.start_pass) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_next) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (cmd.take_slice) begin
            busy_ff[scan_idx_ff] <= (work_after != '0);
            time_ff <= time_sat;
            age_idx_ff <= '0;
         end else if (cmd.age_issue) begin
            age_idx_ff <= age_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      age_idx_d_ff <= age_idx_ff;
      if (cmd.start_pass) begin
         pass_level_ff <= req_level_norm;
         quantum_ff <= (quantum_sel == '0) ? WORK_W'(1) : quantum_sel;
      end
      if (cmd.take_slice) begin
         run_ff <= run_calc;
         start_ff <= time_ff;
         self_rec_ff <= '{work: work_after, arrival: rd_rec.arrival,
                          level: self_level, waited: rd_rec.waited};
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_slice || cmd.out_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_slice) begin
         rsp_slice_valid_ff <= 1'b1;
         rsp_task_slot_ff <= SLOT_W'(scan_idx_ff);
         rsp_start_time_ff <= start_ff;
         rsp_run_length_ff <= run_ff;
         rsp_work_left_ff <= self_rec_ff.work;
         rsp_finished_ff <= (self_rec_ff.work == '0);
         rsp_end_time_ff <= time_ff;
         rsp_all_done_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
      end else if (cmd.out_final) begin
         rsp_slice_valid_ff <= 1'b0;
         rsp_task_slot_ff <= '0;
         rsp_start_time_ff <= '0;
         rsp_run_length_ff <= '0;
         rsp_work_left_ff <= '0;
         rsp_finished_ff <= 1'b0;
         rsp_end_time_ff <= '0;
         rsp_all_done_ff <= (busy_ff == '0);
         rsp_last_ff <= 1'b1;
      end
   end

   assign status.busy_cur = busy_ff[scan_idx_ff];
   assign status.eligible = (rd_rec.level == pass_level_ff) && (rd_rec.arrival <= time_ff);
   assign status.scan_last = (scan_idx_ff == LAST_IDX);
   assign status.age_last = (age_idx_ff == LAST_IDX);
   assign status.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slice_valid = rsp_slice_valid_ff;
   assign rsp_task_slot = rsp_task_slot_ff;
   assign rsp_start_time = rsp_start_time_ff;
   assign rsp_run_length = rsp_run_length_ff;
   assign rsp_work_left = rsp_work_left_ff;
   assign rsp_finished = rsp_finished_ff;
   assign rsp_end_time = rsp_end_time_ff;
   assign rsp_all_done = rsp_all_done_ff;
   assign rsp_last = rsp_last_ff;

`ifndef NO_ASSERTIONS
   ast_slice_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_slice_valid_ff |-> !rsp_last_ff && !rsp_all_done_ff)
      else $error("A slice transaction carries the final marker.");
   ast_finished_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_slice_valid_ff |-> rsp_finished_ff == (rsp_work_left_ff == '0))
      else $error("Finished flag disagrees with the work left.");
   ast_time_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_slice_valid_ff |-> rsp_end_time_ff >= rsp_start_time_ff)
      else $error("Slice ends before it starts.");
   ast_one_writer: assert property (@(posedge clock) disable iff (reset)
      age_we |-> !cmd.self_wr && !cmd.start_load)
      else $error("Two writers on the slot RAM in one cycle.");
`endif

endmodule

// ===== src/mlfq_scheduler_with_aging.sv =====
// Top level of the three-level feedback queue scheduler with aging.
// A load writes its slot on acceptance and then issues its final transaction once the output is free.
// A pass scans the slots in order and, for each slice run, sweeps the whole slot RAM to age waiting tasks.
// One item is in work at a time; the next is accepted once the final result is registered.
// Reset clears the busy bits and the current time and sets the configuration registers to their defaults.
module mlfq_scheduler_with_aging #(
   parameter int TASK_SLOTS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [mlfq_pkg::SLOT_W-1:0]      req_slot,
   input  logic [mlfq_pkg::TIME_W-1:0]      req_arrival_time,
   input  logic [mlfq_pkg::WORK_W-1:0]      req_service_time,
   input  logic [mlfq_pkg::LEVEL_W-1:0]     req_level,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_slice_valid,
   output logic [mlfq_pkg::SLOT_W-1:0]      rsp_task_slot,
   output logic [mlfq_pkg::TIME_W-1:0]      rsp_start_time,
   output logic [mlfq_pkg::WORK_W-1:0]      rsp_run_length,
   output logic [mlfq_pkg::WORK_W-1:0]      rsp_work_left,
   output logic                             rsp_finished,
   output logic [mlfq_pkg::TIME_W-1:0]      rsp_end_time,
   output logic                             rsp_all_done,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [mlfq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import mlfq_pkg::*;

   cmd_type    cmd;
   status_type status;

   mlfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   mlfq_datapath #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_slot         (req_slot),
      .req_arrival_time (req_arrival_time),
      .req_service_time (req_service_time),
      .req_level        (req_level),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slice_valid  (rsp_slice_valid),
      .rsp_task_slot    (rsp_task_slot),
      .rsp_start_time   (rsp_start_time),
      .rsp_run_length   (rsp_run_length),
      .rsp_work_left    (rsp_work_left),
      .rsp_finished     (rsp_finished),
      .rsp_end_time     (rsp_end_time),
      .rsp_all_done     (rsp_all_done),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== sim/mlfq_scheduler_with_aging_tb.sv =====
// Self-checking testbench of the three-level feedback queue scheduler with aging.
module mlfq_scheduler_with_aging_tb;
   import mlfq_pkg::*;

   localparam int SLOTS = 32;
   localparam int SLOT_IDX_W = $clog2(SLOTS);
   localparam int HOLD_CYCLES = 600;
   localparam int DIRECTED_ROWS = 17;

   typedef struct packed {
      logic               slice_valid;
      logic [SLOT_W-1:0]  task_slot;
      logic [TIME_W-1:0]  start_time;
      logic [WORK_W-1:0]  run_length;
      logic [WORK_W-1:0]  work_left;
      logic               finished;
      logic [TIME_W-1:0]  end_time;
      logic               all_done;
      logic               last;
   } report_type;

   typedef struct packed {
      logic               op;
      logic [SLOT_W-1:0]  slot;
      logic [TIME_W-1:0]  arr;
      logic [WORK_W-1:0]  svc;
      logic [LEVEL_W-1:0] lvl;
      bit                 typed;
      bit                 done;
   } row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_opcode;
   logic [SLOT_W-1:0]      req_slot;
   logic [TIME_W-1:0]      req_arrival_time;
   logic [WORK_W-1:0]      req_service_time;
   logic [LEVEL_W-1:0]     req_level;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_slice_valid;
   logic [SLOT_W-1:0]      rsp_task_slot;
   logic [TIME_W-1:0]      rsp_start_time;
   logic [WORK_W-1:0]      rsp_run_length;
   logic [WORK_W-1:0]      rsp_work_left;
   logic                   rsp_finished;
   logic [TIME_W-1:0]      rsp_end_time;
   logic                   rsp_all_done;
   logic                   rsp_last;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   logic [WORK_W-1:0]  slot_work [SLOTS] = '{default: '0};
   logic [TIME_W-1:0]  slot_arrival [SLOTS];
   logic [LEVEL_W-1:0] slot_level [SLOTS];
   logic [TIME_W-1:0]  slot_waited [SLOTS];
   logic [TIME_W-1:0]  sched_time = '0;
   logic [WORK_W-1:0]  quantum_one = QUANTUM_ONE_RESET;
   logic [WORK_W-1:0]  quantum_two = QUANTUM_TWO_RESET;
   logic [WORK_W-1:0]  quantum_three = QUANTUM_THREE_RESET;
   logic [TIME_W-1:0]  wait_limit = WAIT_LIMIT_RESET;

   report_type pending_reports [$];
   row_type    directed_rows [DIRECTED_ROWS];
   bit      row_typed;
   bit      row_done;
   bit      hold_request = 1'b0;
   int      burst_left = 0;
   int      errors = 0;

   mlfq_scheduler_with_aging u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_slot         (req_slot),
      .req_arrival_time (req_arrival_time),
      .req_service_time (req_service_time),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slice_valid  (rsp_slice_valid),
      .rsp_task_slot    (rsp_task_slot),
      .rsp_start_time   (rsp_start_time),
      .rsp_run_length   (rsp_run_length),
      .rsp_work_left    (rsp_work_left),
      .rsp_finished     (rsp_finished),
      .rsp_end_time     (rsp_end_time),
      .rsp_all_done     (rsp_all_done),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   task automatic predict_schedule(input logic op, input logic [SLOT_W-1:0] slot,
                                   input logic [TIME_W-1:0] arr, input logic [WORK_W-1:0] svc,
                                   input logic [LEVEL_W-1:0] lvl_in, input bit typed,
                                   input bit typed_done);
      logic [LEVEL_W-1:0]    lvl;
      logic [WORK_W-1:0]     quantum;
      logic [WORK_W-1:0]     run;
      logic [SLOT_IDX_W-1:0] idx;
      report_type            rep;
      bit                    idle;
      int                    i;
      int                    j;
      lvl = (lvl_in == LEVEL_NONE) ? LEVEL_ONE : lvl_in;
      idx = slot[SLOT_IDX_W-1:0];
      if (op == OP_LOAD) begin
         if (slot < SLOTS) begin
            slot_work[idx] = svc;
            slot_arrival[idx] = arr;
            slot_level[idx] = lvl;
            slot_waited[idx] = '0;
         end
      end else begin
         case (lvl)
            LEVEL_ONE: quantum = quantum_one;
            LEVEL_TWO: quantum = quantum_two;
            default: quantum = quantum_three;
         endcase
         if (quantum == '0) quantum = 8'd1;
         for (i = 0; i < SLOTS; i++) begin
            if (slot_work[i] != '0 && slot_level[i] == lvl && slot_arrival[i] <= sched_time) begin
               run = (slot_work[i] > quantum) ? quantum : slot_work[i];
               rep = '0;
               rep.slice_valid = 1'b1;
               rep.task_slot = SLOT_W'(i);
               rep.start_time = sched_time;
               rep.run_length = run;
               slot_work[i] = slot_work[i] - run;
               sched_time = sat_add(sched_time, {8'd0, run});
               for (j = 0; j < SLOTS; j++) begin
                  if (j != i && slot_work[j] != '0 && slot_arrival[j] <= sched_time) begin
                     slot_waited[j] = sat_add(slot_waited[j], {8'd0, run});
                     if (slot_waited[j] > wait_limit && slot_level[j] > LEVEL_ONE) begin
                        slot_level[j] = slot_level[j] - 2'd1;
                        slot_waited[j] = '0;
                     end
                  end
               end
               if (slot_work[i] != '0 && lvl != LEVEL_THREE) slot_level[i] = lvl + 2'd1;
               rep.work_left = slot_work[i];
               rep.finished = (slot_work[i] == '0);
               rep.end_time = sched_time;
               if (!typed) pending_reports.push_back(rep);
            end
         end
      end
      idle = 1'b1;
      for (i = 0; i < SLOTS; i++) begin
         if (slot_work[i] != '0) idle = 1'b0;
      end
      rep = '0;
      rep.all_done = typed ? typed_done : idle;
      rep.last = 1'b1;
      pending_reports.push_back(rep);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_report();
      report_type want;
      if (pending_reports.size() == 0) begin
         errors++;
         $display("%0t: transaction with none expected, actual slot %0h last %0h",
                  $time, rsp_task_slot, rsp_last);
      end else begin
         want = pending_reports.pop_front();
         compare_field("slice_valid", want.slice_valid, rsp_slice_valid);
         compare_field("task_slot", want.task_slot, rsp_task_slot);
         compare_field("start_time", want.start_time, rsp_start_time);
         compare_field("run_length", want.run_length, rsp_run_length);
         compare_field("work_left", want.work_left, rsp_work_left);
         compare_field("finished", want.finished, rsp_finished);
         compare_field("end_time", want.end_time, rsp_end_time);
         compare_field("all_done", want.all_done, rsp_all_done);
         compare_field("last", want.last, rsp_last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         predict_schedule(req_opcode, req_slot, req_arrival_time, req_service_time, req_level,
                          row_typed, row_done);
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) check_report();
   end

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                            input logic [TIME_W-1:0] arr, input logic [WORK_W-1:0] svc,
                            input logic [LEVEL_W-1:0] lvl, input bit typed, input bit done);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_slot <= slot;
      req_arrival_time <= arr;
      req_service_time <= svc;
      req_level <= lvl;
      row_typed <= typed;
      row_done <= done;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic configure(input logic [WORK_W-1:0] q1, input logic [WORK_W-1:0] q2,
                            input logic [WORK_W-1:0] q3, input logic [TIME_W-1:0] limit);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_QUANTUM_ONE;
      csr_write_data <= {8'($urandom_range(0, 255)), q1};
      @(posedge clock);
      csr_index <= CSR_QUANTUM_TWO;
      csr_write_data <= {8'($urandom_range(0, 255)), q2};
      @(posedge clock);
      csr_index <= CSR_QUANTUM_THREE;
      csr_write_data <= {8'($urandom_range(0, 255)), q3};
      @(posedge clock);
      csr_index <= CSR_WAIT_LIMIT;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      quantum_one = q1;
      quantum_two = q2;
      quantum_three = q3;
      wait_limit = limit;
   endtask

   initial begin
      int mode;
      int stretch;
      int k;
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         mode = $urandom_range(0, 3);
         stretch = $urandom_range(10, 120);
         for (k = 0; k < stretch; k++) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (k % 5 >= 3);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int                 n;
      int                 k;
      int                 r;
      int                 phase;
      int                 extra;
      int                 base;
      logic               op;
      logic [SLOT_W-1:0]  slot;
      logic [TIME_W-1:0]  arr;
      logic [WORK_W-1:0]  svc;
      logic [LEVEL_W-1:0] lvl;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_LOAD;
      req_slot <= '0;
      req_arrival_time <= '0;
      req_service_time <= '0;
      req_level <= LEVEL_ONE;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_QUANTUM_ONE;
      csr_write_data <= '0;
      row_typed <= 1'b0;
      row_done <= 1'b0;
      directed_rows = '{
         '{OP_PASS, 6'd0,  16'h0000, 8'd0,   LEVEL_ONE,   1'b1, 1'b1},
         '{OP_PASS, 6'd63, 16'hFFFF, 8'd255, LEVEL_NONE,  1'b1, 1'b1},
         '{OP_LOAD, 6'd63, 16'hFFFF, 8'd255, LEVEL_THREE, 1'b1, 1'b1},
         '{OP_LOAD, 6'd32, 16'h0000, 8'd1,   LEVEL_ONE,   1'b1, 1'b1},
         '{OP_LOAD, 6'd0,  16'h0000, 8'd0,   LEVEL_ONE,   1'b1, 1'b1},
         '{OP_LOAD, 6'd0,  16'h0000, 8'd5,   LEVEL_NONE,  1'b1, 1'b0},
         '{OP_LOAD, 6'd31, 16'h0000, 8'd255, LEVEL_THREE, 1'b1, 1'b0},
         '{OP_LOAD, 6'd1,  16'h0003, 8'd1,   LEVEL_ONE,   1'b1, 1'b0},
         '{OP_LOAD, 6'd2,  16'hFFFF, 8'd7,   LEVEL_TWO,   1'b1, 1'b0},
         '{OP_PASS, 6'd0,  16'h0000, 8'd0,   LEVEL_ONE,   1'b0, 1'b0},
         '{OP_PASS, 6'd0,  16'h0000, 8'd0,   LEVEL_NONE,  1'b0, 1'b0},
         '{OP_PASS, 6'd0,  16'h0000, 8'd0,   LEVEL_THREE, 1'b0, 1'b0},
         '{OP_PASS, 6'd0,  16'h0000, 8'd0,   LEVEL_TWO,   1'b0, 1'b0},
         '{OP_PASS, 6'd0,  16'h0000, 8'd0,   LEVEL_ONE,   1'b0, 1'b0},
         '{OP_LOAD, 6'd3,  16'h0000, 8'd1,   LEVEL_TWO,   1'b0, 1'b0},
         '{OP_PASS, 6'd0,  16'h0000, 8'd0,   LEVEL_TWO,   1'b0, 1'b0},
         '{OP_PASS, 6'd0,  16'h0000, 8'd0,   LEVEL_THREE, 1'b0, 1'b0}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         pace();
         send_item(directed_rows[n].op, directed_rows[n].slot, directed_rows[n].arr,
                   directed_rows[n].svc, directed_rows[n].lvl, directed_rows[n].typed,
                   directed_rows[n].done);
      end

      for (phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: configure(8'd1, 8'd3, 8'd255, 16'd0);
            1: configure(8'd255, 8'd255, 8'd255, 16'hFFFF);
            2: configure(8'd0, 8'd0, 8'd0, 16'd2);
            default: configure(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                               8'($urandom_range(1, 12)), 16'($urandom_range(0, 40)));
         endcase
         if (phase == 1) hold_request = 1'b1;
         for (n = 0; n < 35; n++) begin
            op = ($urandom_range(0, 99) < 55) ? OP_LOAD : OP_PASS;
            slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(32, 63))
                                               : SLOT_W'($urandom_range(0, 31));
            r = $urandom_range(0, 99);
            if (r < 60) begin
               arr = sat_add((sched_time > 16'd8) ? sched_time - 16'd8 : 16'd0,
                             16'($urandom_range(0, 24)));
            end else if (r < 80) begin
               arr = 16'($urandom_range(0, sched_time));
            end else begin
               arr = 16'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 10) svc = '0;
            else if (r < 70) svc = 8'($urandom_range(1, 12));
            else svc = 8'($urandom_range(1, 255));
            lvl = LEVEL_W'($urandom_range(0, 3));
            pace();
            send_item(op, slot, arr, svc, lvl, 1'b0, 1'b0);
         end
      end

      drain();
      configure(8'd255, 8'd255, 8'd255, 16'hFFFF);
      k = 0;
      extra = 0;
      base = $urandom_range(0, SLOTS - 1);
      while (extra < 12 && k < 400) begin
         if (k % 9 == 8) begin
            op = OP_PASS;
            lvl = ($urandom_range(0, 5) == 0) ? LEVEL_ONE : LEVEL_THREE;
            slot = SLOT_W'($urandom);
            arr = 16'($urandom);
            svc = 8'($urandom);
         end else begin
            op = OP_LOAD;
            slot = SLOT_W'((base + k) % SLOTS);
            arr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, sched_time));
            svc = 8'($urandom_range(224, 255));
            lvl = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom_range(0, 3)) : LEVEL_THREE;
         end
         pace();
         send_item(op, slot, arr, svc, lvl, 1'b0, 1'b0);
         if (sched_time == '1) extra++;
         k++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      k = 0;
      while (pending_reports.size() != 0 && k < 400000) begin
         @(posedge clock);
         k++;
      end
      if (pending_reports.size() != 0) begin
         errors++;
         $display("%0t: %0d expected transactions never arrived", $time,
                  pending_reports.size());
      end
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
src/mlfq_pkg.sv
src/mlfq_ram.sv
src/mlfq_ctrl.sv
src/mlfq_datapath.sv
src/mlfq_scheduler_with_aging.sv
sim/mlfq_scheduler_with_aging_tb.sv
